// ===== rtl/lnasm_pkg.sv =====
// ----------------------------------------------------------------------------
// lnasm_pkg
// Shared constants and control types of the line assembler.
// ----------------------------------------------------------------------------
package lnasm_pkg;

  localparam int unsigned LINE_DEPTH_DEFAULT = 64;
  localparam int unsigned MAX_LINE = 64;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned LEN_W = 6;
  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT = 1'b1;

  localparam logic [BYTE_W-1:0] TERMINATOR_RESET = 8'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
  localparam logic [LIMIT_W-1:0] LIMIT_MIN = 7'd2;

  localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OVER = 2'd2;

  typedef struct packed {
    logic capture;
    logic store_char;
    logic start_run;
    logic load_char;
    logic load_empty;
    logic load_run;
    logic advance;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_term;
    logic is_full;
    logic count_zero;
    logic out_free;
    logic run_last;
  } stat_t;

endpackage

// ===== rtl/lnasm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lnasm_ctrl
// Sequencer that classifies each byte and steps through line read-out.
// ----------------------------------------------------------------------------
module lnasm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lnasm_pkg::stat_t  stat_i,
  output lnasm_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_CHAR,
    S_EMPTY,
    S_RD,
    S_SHOW
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        if (stat_i.is_term && stat_i.count_zero) begin
          state_d = S_EMPTY;
        end else if (stat_i.is_term || stat_i.is_full) begin
          cmd_o.start_run = 1'b1;
          state_d = S_RD;
        end else begin
          cmd_o.store_char = 1'b1;
          state_d = S_CHAR;
        end
      end
      S_CHAR: begin
        if (stat_i.out_free) begin
          cmd_o.load_char = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (stat_i.out_free) begin
          cmd_o.load_empty = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        state_d = S_SHOW;
      end
      S_SHOW: begin
        if (stat_i.out_free) begin
          cmd_o.load_run = 1'b1;
          if (stat_i.run_last) begin
            cmd_o.finish = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ===== rtl/lnasm_dp.sv =====
// ----------------------------------------------------------------------------
// lnasm_dp
// Line store, count, configuration registers and the output register.
// ----------------------------------------------------------------------------
module lnasm_dp #(
  parameter int unsigned LINE_DEPTH = lnasm_pkg::LINE_DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lnasm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lnasm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [lnasm_pkg::BYTE_W-1:0]        rx_byte_i,
  input  lnasm_pkg::cmd_t                     cmd_i,
  output lnasm_pkg::stat_t                    stat_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lnasm_pkg::KIND_W-1:0]        event_kind_o,
  output logic [lnasm_pkg::BYTE_W-1:0]        data_byte_o,
  output logic [lnasm_pkg::LEN_W-1:0]         line_length_o,
  output logic                                last_of_run_o
);

  localparam int unsigned STORE_DEPTH =
      (LINE_DEPTH < lnasm_pkg::MAX_LINE) ? LINE_DEPTH : lnasm_pkg::MAX_LINE;
  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [lnasm_pkg::LIMIT_W-1:0] LIMIT_TOP =
      lnasm_pkg::LIMIT_W'(STORE_DEPTH);

  logic [lnasm_pkg::BYTE_W-1:0]  term_q;
  logic [lnasm_pkg::LIMIT_W-1:0] limit_q;
  logic [lnasm_pkg::LIMIT_W-1:0] eff_limit;
  logic [lnasm_pkg::LEN_W-1:0]   count_q;
  logic [lnasm_pkg::LEN_W-1:0]   idx_q;
  logic [lnasm_pkg::BYTE_W-1:0]  byte_q;
  logic [lnasm_pkg::KIND_W-1:0]  kind_q;
  logic [lnasm_pkg::BYTE_W-1:0]  rd_data_q;
  logic [lnasm_pkg::BYTE_W-1:0]  mem [STORE_DEPTH];
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;

  logic                          out_valid_q;
  logic [lnasm_pkg::KIND_W-1:0]  out_kind_q;
  logic [lnasm_pkg::BYTE_W-1:0]  out_data_q;
  logic [lnasm_pkg::LEN_W-1:0]   out_len_q;
  logic                          out_last_q;

  always_comb begin
    priority if (limit_q < lnasm_pkg::LIMIT_MIN) begin
      eff_limit = lnasm_pkg::LIMIT_MIN;
    end else if (limit_q > LIMIT_TOP) begin
      eff_limit = LIMIT_TOP;
    end else begin
      eff_limit = limit_q;
    end
  end

  assign stat_o.is_term    = (byte_q == term_q);
  assign stat_o.is_full    = ({1'b0, count_q} + 7'd1) >= eff_limit;
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;
  assign stat_o.run_last   = ({1'b0, idx_q} + 7'd1) == {1'b0, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q  <= lnasm_pkg::TERMINATOR_RESET;
      limit_q <= lnasm_pkg::LIMIT_RESET;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lnasm_pkg::CFG_TERMINATOR: term_q <= cfg_data_i;
          lnasm_pkg::CFG_LINE_LIMIT: limit_q <= cfg_data_i[lnasm_pkg::LIMIT_W-1:0];
          default: term_q <= term_q;
        endcase
      end
      if (cfg_we_i && (cfg_idx_i == lnasm_pkg::CFG_LINE_LIMIT)) begin
        count_q <= '0;
      end else if (cmd_i.store_char) begin
        count_q <= count_q + 6'd1;
      end else if (cmd_i.load_empty) begin
        count_q <= '0;
      end else if (cmd_i.finish) begin
        count_q <= (kind_q == lnasm_pkg::KIND_OVER) ? 6'd1 : 6'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      byte_q <= rx_byte_i;
    end
    if (cmd_i.start_run) begin
      kind_q <= stat_o.is_term ? lnasm_pkg::KIND_LINE : lnasm_pkg::KIND_OVER;
      idx_q  <= '0;
    end else if (cmd_i.advance) begin
      idx_q <= idx_q + 6'd1;
    end
  end

  assign mem_we    = cmd_i.store_char || (cmd_i.finish && (kind_q == lnasm_pkg::KIND_OVER));
  assign mem_waddr = cmd_i.store_char ? count_q[AW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= byte_q;
    end
    rd_data_q <= mem[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_char || cmd_i.load_empty || cmd_i.load_run) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_char) begin
      out_kind_q <= lnasm_pkg::KIND_CHAR;
      out_data_q <= byte_q;
      out_len_q  <= count_q;
      out_last_q <= 1'b1;
    end else if (cmd_i.load_empty) begin
      out_kind_q <= lnasm_pkg::KIND_LINE;
      out_data_q <= '0;
      out_len_q  <= '0;
      out_last_q <= 1'b1;
    end else if (cmd_i.load_run) begin
      out_kind_q <= kind_q;
      out_data_q <= rd_data_q;
      out_len_q  <= count_q;
      out_last_q <= stat_o.run_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = out_kind_q;
  assign data_byte_o   = out_data_q;
  assign line_length_o = out_len_q;
  assign last_of_run_o = out_last_q;

endmodule

// ===== rtl/line_assembler_with_overflow.sv =====
// ----------------------------------------------------------------------------
// line_assembler_with_overflow
// Builds text lines from received bytes and reports them as event runs.
//
// Bytes enter on the input channel (in_valid_i, in_stall_o, rx_byte_i), one
// item at a time. Each accepted byte produces one or more events on the output
// channel (out_valid_o, out_stall_i and the event fields); the final event of
// a byte carries last_of_run_o. A byte equal to the terminator reports the
// stored line, one event per byte, or one empty-line event if none is stored.
// A byte that meets the line limit reports the stored line as an overflow run
// and starts the next line; any other byte is echoed once. Each run byte is
// read from the line store, then placed in the output register. The next byte
// is taken once the last event of the previous byte is in the output register,
// even while that event still waits to be transferred. When the receiver
// stalls, the output register holds its event and the sequencer waits. Reset
// clears the count, the terminator to zero and the line limit to 64; the store
// contents are not cleared. Configuration must be written through cfg_we_i,
// cfg_idx_i and cfg_data_i only while the block is idle; this is not enforced.
// ----------------------------------------------------------------------------
module line_assembler_with_overflow #(
  parameter int unsigned LINE_DEPTH = lnasm_pkg::LINE_DEPTH_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lnasm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lnasm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [lnasm_pkg::BYTE_W-1:0]     rx_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [lnasm_pkg::KIND_W-1:0]     event_kind_o,
  output logic [lnasm_pkg::BYTE_W-1:0]     data_byte_o,
  output logic [lnasm_pkg::LEN_W-1:0]      line_length_o,
  output logic                             last_of_run_o
);

  lnasm_pkg::cmd_t  cmd;
  lnasm_pkg::stat_t stat;

  lnasm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lnasm_dp #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .rx_byte_i     (rx_byte_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_kind_o  (event_kind_o),
    .data_byte_o   (data_byte_o),
    .line_length_o (line_length_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== verif/tb_line_assembler_with_overflow.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_assembler_with_overflow
// Self-checking testbench for the line assembler with overflow.
//
// A scoreboard class keeps its own copy of the terminator, the line limit, the
// line store and the character count, and works out the events that every
// accepted byte must cause. A monitor compares each output transfer with the
// oldest pending event, field by field. A short directed sequence covers empty
// lines, overflow at small limits, saturated limits and a terminator change in
// the middle of a line. Random phases then send well-formed lines with random
// content and some noise under several register settings, while the sender
// idles in bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_line_assembler_with_overflow;
  import lnasm_pkg::*;

  localparam int unsigned DEPTH = LINE_DEPTH_DEFAULT;
  localparam int unsigned RANDOM_BYTES = 425;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              last;
  } line_event_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_LONG, STALL_TOGGLE} stall_mode_t;

  class line_scoreboard;
    logic [BYTE_W-1:0]  term;
    logic [LIMIT_W-1:0] limit;
    logic [BYTE_W-1:0]  store [DEPTH];
    logic [LEN_W-1:0]   count;
    line_event_t        pending [$];
    int                 errors;

    function new();
      term   = TERMINATOR_RESET;
      limit  = LIMIT_RESET;
      count  = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_TERMINATOR) begin
        term = value[BYTE_W-1:0];
      end else if (idx == CFG_LINE_LIMIT) begin
        limit = value[LIMIT_W-1:0];
        count = '0;
      end
    endfunction

    function int unsigned eff_limit();
      int unsigned top;
      int unsigned lim;
      top = (DEPTH < MAX_LINE) ? DEPTH : MAX_LINE;
      lim = limit;
      if (top < 2) top = 2;
      if (lim < 2) lim = 2;
      if (lim > top) lim = top;
      return lim;
    endfunction

    function void push_run(logic [KIND_W-1:0] kind);
      if (count == 0) begin
        pending.push_back('{kind, '0, '0, 1'b1});
      end else begin
        for (int i = 0; i < count; i++) begin
          pending.push_back('{kind, store[i % DEPTH], count, (i + 1 == count)});
        end
      end
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      if (b == term) begin
        push_run(KIND_LINE);
        count = '0;
      end else if (count >= eff_limit() - 1) begin
        push_run(KIND_OVER);
        store[0] = b;
        count = 6'd1;
      end else begin
        store[count % DEPTH] = b;
        count = count + 1'b1;
        pending.push_back('{KIND_CHAR, b, count, 1'b1});
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_event(line_event_t got);
      line_event_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected event kind=%0d data=%02h len=%0d last=%0d",
                         got.kind, got.data, got.len, got.last));
      end else begin
        want = pending.pop_front();
        if (got.kind !== want.kind)
          report($sformatf("event_kind %0d, expected %0d", got.kind, want.kind));
        if (got.data !== want.data)
          report($sformatf("data_byte %02h, expected %02h", got.data, want.data));
        if (got.len !== want.len)
          report($sformatf("line_length %0d, expected %0d", got.len, want.len));
        if (got.last !== want.last)
          report($sformatf("last_of_run %0d, expected %0d", got.last, want.last));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [BYTE_W-1:0]     rx_byte;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [KIND_W-1:0]     event_kind;
  logic [BYTE_W-1:0]     data_byte;
  logic [LEN_W-1:0]      line_length;
  logic                  last_of_run;

  line_scoreboard sb = new();
  int unsigned    burst_left = 0;
  int unsigned    random_sent = 0;
  stall_mode_t    stall_mode = STALL_NONE;
  int unsigned    mode_left = 0;
  int unsigned    stall_left = 0;

  line_assembler_with_overflow #(.LINE_DEPTH(DEPTH)) u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .event_kind_o  (event_kind),
    .data_byte_o   (data_byte),
    .line_length_o (line_length),
    .last_of_run_o (last_of_run)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end
      STALL_LONG: begin
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
          if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
        end
      end
      default: begin
        out_stall <= ~out_stall;
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_event('{event_kind, data_byte, line_length, last_of_run});
    end
  end

  task send_byte(logic [BYTE_W-1:0] b);
    int unsigned gap;
    @(negedge clk);
    in_valid = 1'b1;
    rx_byte  = b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    @(negedge clk);
    in_valid = 1'b0;
    rx_byte  = BYTE_W'($urandom_range(0, 255));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
    end
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, value);
  endtask

  task wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task send_random_byte(bit as_noise);
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(0, 255));
    while (!as_noise && b == sb.term) b = BYTE_W'($urandom_range(0, 255));
    send_byte(b);
    random_sent++;
  endtask

  task run_phase(int unsigned quota);
    int unsigned stop_at;
    int unsigned eff;
    int unsigned line_len;
    stop_at = random_sent + quota;
    eff     = sb.eff_limit();
    while (random_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) line_len = $urandom_range(eff - 1, eff + 3);
      else line_len = $urandom_range(0, eff);
      for (int i = 0; i < line_len && random_sent < stop_at; i++) begin
        send_random_byte($urandom_range(0, 15) == 0);
      end
      if (random_sent < stop_at && $urandom_range(0, 7) != 0) begin
        send_byte(sb.term);
        random_sent++;
      end
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] lim_value;
    int unsigned           quota;
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_TERMINATOR;
    cfg_data = '0;
    in_valid = 1'b0;
    rx_byte  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h00);
    wait_drained();

    write_reg(CFG_TERMINATOR, 8'h0A);
    write_reg(CFG_LINE_LIMIT, 8'd3);
    send_byte("a");
    send_byte("b");
    send_byte("c");
    send_byte(8'h00);
    send_byte(8'h0A);
    send_byte(8'h0A);
    wait_drained();

    write_reg(CFG_LINE_LIMIT, 8'd0);
    send_byte("x");
    send_byte("y");
    send_byte(8'h0A);
    wait_drained();

    write_reg(CFG_LINE_LIMIT, 8'hC8);
    write_reg(CFG_TERMINATOR, 8'hFF);
    send_byte("q");
    send_byte(8'hFF);
    send_byte(8'h0A);
    wait_drained();

    write_reg(CFG_LINE_LIMIT, 8'd1);
    send_byte("z");
    send_byte("w");
    wait_drained();

    write_reg(CFG_TERMINATOR, 8'h55);
    send_byte(8'hFF);
    send_byte(8'h55);
    wait_drained();

    while (random_sent < RANDOM_BYTES) begin
      case ($urandom_range(0, 3))
        0: write_reg(CFG_TERMINATOR, 8'h00);
        1: write_reg(CFG_TERMINATOR, 8'hFF);
        2: write_reg(CFG_TERMINATOR, CFG_DATA_W'($urandom_range(0, 255)));
        default: ;
      endcase
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 7))
          0: lim_value = 8'd0;
          1: lim_value = 8'd2;
          2: lim_value = 8'd3;
          3: lim_value = 8'd64;
          4: lim_value = CFG_DATA_W'($urandom_range(65, 255));
          5: lim_value = CFG_DATA_W'($urandom_range(4, 16));
          default: lim_value = CFG_DATA_W'($urandom_range(2, 64));
        endcase
        write_reg(CFG_LINE_LIMIT, lim_value);
      end
      quota = $urandom_range(30, 80);
      if (quota > RANDOM_BYTES - random_sent) quota = RANDOM_BYTES - random_sent;
      run_phase(quota);
      wait_drained();
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** line_assembler_with_overflow: PASSED **");
    end else begin
      $display("** line_assembler_with_overflow: FAILED **");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("** line_assembler_with_overflow: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lnasm_pkg.sv
rtl/lnasm_ctrl.sv
rtl/lnasm_dp.sv
rtl/line_assembler_with_overflow.sv
verif/tb_line_assembler_with_overflow.sv
